### rtl/core/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg
// Shared widths, request codes and the command broadcast to the list cells.
// ----------------------------------------------------------------------------
package oal_pkg;

	localparam int KIND_W = 2;
	localparam int POS_W  = 6;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_READ   = 2'd0,
		KIND_LOCATE = 2'd1,
		KIND_INSERT = 2'd2,
		KIND_DELETE = 2'd3
	} kind_t;

	// Command seen by every cell in the cycle a request transfers.
	// ins is only set for an insert that fits and del only for an in-range delete.
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

endpackage

### rtl/core/oal_req_if.sv
// ----------------------------------------------------------------------------
// oal_req_if
// Request channel: valid/ready handshake with kind, position and value.
// ----------------------------------------------------------------------------
interface oal_req_if;
	logic                             valid;
	logic                             ready;
	logic [oal_pkg::KIND_W-1:0]       kind;
	logic [oal_pkg::POS_W-1:0]        position;
	logic signed [oal_pkg::VAL_W-1:0] value;

	modport source (output valid, output kind, output position, output value, input ready);
	modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

### rtl/core/oal_rsp_if.sv
// ----------------------------------------------------------------------------
// oal_rsp_if
// Response channel: valid/ready handshake with status, index, element, count.
// ----------------------------------------------------------------------------
interface oal_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             ok;
	logic [oal_pkg::POS_W-1:0]        found_index;
	logic signed [oal_pkg::VAL_W-1:0] element;
	logic [oal_pkg::CNT_W-1:0]        count;

	modport source (output valid, output ok, output found_index, output element,
		output count, input ready);
	modport sink   (input valid, input ok, input found_index, input element,
		input count, output ready);
endinterface

### rtl/core/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: loads, shifts up from its left neighbor or down from its
// right neighbor, and compares its word against the broadcast key.
// ----------------------------------------------------------------------------
module oal_cell #(
	parameter int CAPACITY = 64,
	parameter int IDX      = 0
) (
	input  logic                             clk,
	input  oal_pkg::cmd_t                    cmd,
	input  logic signed [oal_pkg::VAL_W-1:0] left,
	input  logic signed [oal_pkg::VAL_W-1:0] right,
	output logic signed [oal_pkg::VAL_W-1:0] slot,
	output logic                             match
);
	localparam int AW = ($clog2(CAPACITY) > oal_pkg::POS_W) ? $clog2(CAPACITY)
		: oal_pkg::POS_W;
	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	logic signed [oal_pkg::VAL_W-1:0] slot_q;
	logic [AW-1:0]                    pos_w;

	assign pos_w = AW'(cmd.pos);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == pos_w) begin
				slot_q <= cmd.value;
			end else if (MY_IDX > pos_w) begin
				slot_q <= left;
			end
		end else if (cmd.del && MY_IDX >= pos_w) begin
			slot_q <= right;
		end
	end

	assign slot  = slot_q;
	assign match = (slot_q == cmd.value);
endmodule

### rtl/core/oal_pick.sv
// ----------------------------------------------------------------------------
// oal_pick
// Second stage: first-match index from the registered match vector and the
// element picked by the registered one-hot read select.
// ----------------------------------------------------------------------------
module oal_pick #(
	parameter int CAPACITY = 64
) (
	input  logic [CAPACITY-1:0]              match,
	input  logic [CAPACITY-1:0]              sel,
	input  logic signed [oal_pkg::VAL_W-1:0] slots [CAPACITY],
	output logic                             any,
	output logic [oal_pkg::POS_W-1:0]        index,
	output logic signed [oal_pkg::VAL_W-1:0] element
);
	logic [CAPACITY-1:0] first;

	// Isolate the lowest set bit.
	assign first = match & (~match + CAPACITY'(1));
	assign any   = |match;

	always_comb begin
		index   = '0;
		element = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) index = index | oal_pkg::POS_W'(i);
			if (sel[i])   element = element | slots[i];
		end
	end
endmodule

### rtl/core/ordered_array_list_top.sv
// ----------------------------------------------------------------------------
// ordered_array_list_top
// Positional list of signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, position, value) and each one gives exactly
// one response on rsp (ok, found_index, element, count), in order.
// Kinds: read at position, locate first match of value, insert value at
// position, delete at position. A bad position, a full list on insert or a
// missing key returns ok low and leaves the list unchanged.
// Insert and delete rewrite cells from the position up on transfer. Read and
// locate sample per-cell select and compare bits into one register stage;
// the next cycle picks the element and the first matching index.
// Throughput: one request per cycle while rsp is taken.
// The output register and the stage before it form a two-deep queue: a
// stalled receiver holds the response, and req drops ready once the stage
// behind the output register is also full.
// Reset clears the count and the valid flags; slot contents stay undefined
// and are never returned before they are written.
// ----------------------------------------------------------------------------
module ordered_array_list_top #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	oal_req_if.sink           req,
	oal_rsp_if.source         rsp
);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > oal_pkg::POS_W) ? LW : oal_pkg::POS_W;
	localparam logic [LW-1:0] FULL = LW'(CAPACITY);

	logic [LW-1:0]   len_q;
	logic [CW-1:0]   len_c;
	logic [CW-1:0]   pos_c;
	logic            xfer;
	logic            adv;
	logic            in_range;
	logic            ins_ok;
	logic            del_ok;
	logic            rd_ok;
	oal_pkg::kind_t  kind;
	oal_pkg::cmd_t   cmd;
	logic [LW-1:0]   len_next;

	logic signed [oal_pkg::VAL_W-1:0] slot_w [CAPACITY];
	logic [CAPACITY-1:0]              match_w;
	logic [CAPACITY-1:0]              live_w;
	logic [CAPACITY-1:0]              sel_w;

	logic                        vld_s1;
	logic                        ok_s1;
	logic [oal_pkg::CNT_W-1:0]   cnt_s1;
	logic [CAPACITY-1:0]         match_s1;
	logic [CAPACITY-1:0]         sel_s1;

	logic                             pick_any;
	logic [oal_pkg::POS_W-1:0]        pick_idx;
	logic signed [oal_pkg::VAL_W-1:0] pick_elem;

	logic                             out_vld_q;
	logic                             ok_q;
	logic [oal_pkg::POS_W-1:0]        idx_q;
	logic signed [oal_pkg::VAL_W-1:0] elem_q;
	logic [oal_pkg::CNT_W-1:0]        cnt_q;

	assign kind     = oal_pkg::kind_t'(req.kind);
	assign len_c    = CW'(len_q);
	assign pos_c    = CW'(req.position);
	assign in_range = pos_c < len_c;
	assign rd_ok    = (kind == oal_pkg::KIND_READ) && in_range;
	assign del_ok   = (kind == oal_pkg::KIND_DELETE) && in_range;
	assign ins_ok   = (kind == oal_pkg::KIND_INSERT) && (len_q != FULL) && (pos_c <= len_c);

	assign adv       = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign xfer      = req.valid && req.ready;

	assign cmd.ins   = xfer && ins_ok;
	assign cmd.del   = xfer && del_ok;
	assign cmd.pos   = req.position;
	assign cmd.value = req.value;

	always_comb begin
		len_next = len_q;
		if (cmd.ins) begin
			len_next = len_q + LW'(1);
		end else if (cmd.del) begin
			len_next = len_q - LW'(1);
		end
	end

	generate
		for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
			localparam logic [CW-1:0] G_IDX = CW'(g);
			logic signed [oal_pkg::VAL_W-1:0] left_w;
			logic signed [oal_pkg::VAL_W-1:0] right_w;

			if (g == 0) begin : g_first
				assign left_w = req.value;
			end else begin : g_mid
				assign left_w = slot_w[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_w = slot_w[g];
			end else begin : g_inner
				assign right_w = slot_w[g+1];
			end

			oal_cell #(
				.CAPACITY (CAPACITY),
				.IDX      (g)
			) u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.left  (left_w),
				.right (right_w),
				.slot  (slot_w[g]),
				.match (match_w[g])
			);

			assign live_w[g] = G_IDX < len_c;
			assign sel_w[g]  = rd_ok && (G_IDX == pos_c);
		end
	endgenerate

	// Stage 1: per-cell compare and select bits, taken against the list
	// as it stood before this request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			len_q  <= '0;
		end else begin
			len_q <= len_next;
			if (xfer) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			ok_s1    <= rd_ok || ins_ok || del_ok;
			cnt_s1   <= oal_pkg::CNT_W'(len_next);
			match_s1 <= (kind == oal_pkg::KIND_LOCATE) ? (match_w & live_w) : '0;
			sel_s1   <= sel_w;
		end
	end

	oal_pick #(
		.CAPACITY (CAPACITY)
	) u_pick (
		.match   (match_s1),
		.sel     (sel_s1),
		.slots   (slot_w),
		.any     (pick_any),
		.index   (pick_idx),
		.element (pick_elem)
	);

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q   <= ok_s1 || pick_any;
			idx_q  <= pick_idx;
			elem_q <= pick_elem;
			cnt_q  <= cnt_s1;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.ok          = ok_q;
	assign rsp.found_index = idx_q;
	assign rsp.element     = elem_q;
	assign rsp.count       = cnt_q;
endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Randomized check of ordered_array_list_top: a clocked driver sends list
// requests from a backlog that a stimulus process keeps topped up, a clocked
// monitor takes responses with random back-pressure, and every response is
// compared against a behavioral copy of the list updated at each transfer.
// ----------------------------------------------------------------------------
module tb;

	localparam int          LIST_CAP     = 64;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned FILL_ITEMS   = 70;
	localparam int unsigned IDLE_PCT     = 19;
	localparam int unsigned HOLD_CYCLES  = 120;
	localparam int unsigned STUCK_LIMIT  = 2000;
	localparam int unsigned PRINT_CAP    = 100;

	localparam logic signed [oal_pkg::VAL_W-1:0] VAL_MIN =
		{1'b1, {(oal_pkg::VAL_W-1){1'b0}}};
	localparam logic signed [oal_pkg::VAL_W-1:0] VAL_MAX =
		{1'b0, {(oal_pkg::VAL_W-1){1'b1}}};

	typedef struct packed {
		oal_pkg::kind_t                   kind;
		logic [oal_pkg::POS_W-1:0]        position;
		logic signed [oal_pkg::VAL_W-1:0] value;
	} list_req_t;

	typedef struct packed {
		logic                             ok;
		logic [oal_pkg::POS_W-1:0]        found_index;
		logic signed [oal_pkg::VAL_W-1:0] element;
		logic [oal_pkg::CNT_W-1:0]        count;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	oal_req_if req ();
	oal_rsp_if rsp ();

	ordered_array_list_top #(
		.CAPACITY (LIST_CAP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #6 clk = ~clk;

	// Behavioral list, advanced once per accepted request
	logic signed [oal_pkg::VAL_W-1:0] list_mem [LIST_CAP];
	int unsigned                      list_len = 0;

	list_req_t   req_backlog [$];
	list_rsp_t   rsp_due [$];
	list_req_t   next_req;
	list_req_t   took;
	list_rsp_t   want;
	int unsigned cyc;
	int unsigned stuck;
	int unsigned hold_left;
	int unsigned rsp_seen = 0;
	int unsigned mismatches = 0;

	wire steady = (cyc >= 900) && (cyc < 1500);

	function automatic list_rsp_t list_update(list_req_t r);
		list_rsp_t res;
		int unsigned i;
		res = '0;
		case (r.kind)
			oal_pkg::KIND_READ: begin
				if (r.position < list_len) begin
					res.ok      = 1'b1;
					res.element = list_mem[r.position];
				end
			end
			oal_pkg::KIND_LOCATE: begin
				for (i = 0; i < list_len; i++) begin
					if (!res.ok && list_mem[i] == r.value) begin
						res.ok          = 1'b1;
						res.found_index = i[oal_pkg::POS_W-1:0];
					end
				end
			end
			oal_pkg::KIND_INSERT: begin
				if (list_len < LIST_CAP && r.position <= list_len) begin
					for (i = list_len; i > r.position; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[r.position] = r.value;
					list_len++;
					res.ok = 1'b1;
				end
			end
			default: begin
				if (r.position < list_len) begin
					for (i = r.position; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
					res.ok = 1'b1;
				end
			end
		endcase
		res.count = list_len[oal_pkg::CNT_W-1:0];
		return res;
	endfunction

	task automatic log_mismatch(string what, longint got, longint exp_val);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s mismatch at response %0d: got %0d, want %0d",
				$time, what, rsp_seen, got, exp_val);
	endtask

	task automatic queue_req(oal_pkg::kind_t k, int unsigned p,
			logic signed [oal_pkg::VAL_W-1:0] v);
		list_req_t r;
		r.kind     = k;
		r.position = p[oal_pkg::POS_W-1:0];
		r.value    = v;
		req_backlog.push_back(r);
	endtask

	// Cycle count and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc   <= 0;
			stuck <= 0;
		end else begin
			cyc <= cyc + 1;
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				stuck <= 0;
			end else if (stuck >= STUCK_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid    <= 1'b0;
			req.kind     <= oal_pkg::KIND_READ;
			req.position <= '0;
			req.value    <= '0;
		end else begin
			if (req.valid && req.ready) begin
				took.kind     = oal_pkg::kind_t'(req.kind);
				took.position = req.position;
				took.value    = req.value;
				rsp_due.push_back(list_update(took));
			end
			if (!req.valid || req.ready) begin
				if (req_backlog.size() > 0 &&
						(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_req = req_backlog.pop_front();
					req.valid    <= 1'b1;
					req.kind     <= next_req.kind;
					req.position <= next_req.position;
					req.value    <= next_req.value;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (rsp_due.size() == 0) begin
					log_mismatch("unexpected response, count", rsp.count, -1);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.ok !== want.ok)
						log_mismatch("ok", rsp.ok, want.ok);
					if (rsp.found_index !== want.found_index)
						log_mismatch("found_index", rsp.found_index, want.found_index);
					if (rsp.element !== want.element)
						log_mismatch("element", rsp.element, want.element);
					if (rsp.count !== want.count)
						log_mismatch("count", rsp.count, want.count);
				end
				rsp_seen++;
			end
			// long hold lets the block fill up and stall its request side
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 1'b0;
			end else if (cyc == 300 || cyc == 1800) begin
				hold_left <= HOLD_CYCLES;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Stimulus
	initial begin : stimulus
		int unsigned n;
		int unsigned mode;
		int unsigned pick;
		int unsigned top;
		list_req_t   r;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list: every request fails
		queue_req(oal_pkg::KIND_READ,   0, 0);
		queue_req(oal_pkg::KIND_DELETE, 0, 0);
		queue_req(oal_pkg::KIND_LOCATE, 0, 0);
		queue_req(oal_pkg::KIND_INSERT, 1, 5);
		// build -1, -1, min, max, 0
		queue_req(oal_pkg::KIND_INSERT, 0, VAL_MIN);
		queue_req(oal_pkg::KIND_INSERT, 1, VAL_MAX);
		queue_req(oal_pkg::KIND_INSERT, 0, -1);
		queue_req(oal_pkg::KIND_INSERT, 1, -1);
		queue_req(oal_pkg::KIND_INSERT, 63, 7);
		queue_req(oal_pkg::KIND_INSERT, 4, 0);
		queue_req(oal_pkg::KIND_READ,   0, 0);
		queue_req(oal_pkg::KIND_READ,   4, 0);
		queue_req(oal_pkg::KIND_READ,   5, 0);
		queue_req(oal_pkg::KIND_READ,   63, 0);
		queue_req(oal_pkg::KIND_LOCATE, 0, VAL_MAX);
		queue_req(oal_pkg::KIND_LOCATE, 0, -1);
		queue_req(oal_pkg::KIND_LOCATE, 0, 12345);
		queue_req(oal_pkg::KIND_DELETE, 0, 0);
		queue_req(oal_pkg::KIND_DELETE, 3, 0);
		queue_req(oal_pkg::KIND_DELETE, 3, 0);
		queue_req(oal_pkg::KIND_DELETE, 63, 0);
		queue_req(oal_pkg::KIND_LOCATE, 0, 0);
		queue_req(oal_pkg::KIND_READ,   2, 0);

		// fill to capacity, then keep inserting into the full list
		for (n = 0; n < FILL_ITEMS; n++) begin
			while (req_backlog.size() >= 2) @(negedge clk);
			top = (list_len > 63) ? 63 : list_len;
			queue_req(oal_pkg::KIND_INSERT, $urandom_range(0, top), $urandom);
		end

		// phases of 100: grow, mixed, shrink, mixed
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			while (req_backlog.size() >= 2) @(negedge clk);
			mode = (n / 100) % 4;
			pick = $urandom_range(0, 99);
			case (mode)
				0: r.kind = (pick < 70) ? oal_pkg::KIND_INSERT :
					(pick < 80) ? oal_pkg::KIND_READ :
					(pick < 90) ? oal_pkg::KIND_LOCATE : oal_pkg::KIND_DELETE;
				2: r.kind = (pick < 20) ? oal_pkg::KIND_INSERT :
					(pick < 70) ? oal_pkg::KIND_DELETE :
					(pick < 85) ? oal_pkg::KIND_READ : oal_pkg::KIND_LOCATE;
				default: r.kind = oal_pkg::kind_t'(pick % 4);
			endcase

			case ($urandom_range(0, 9))
				0:       r.value = VAL_MIN;
				1:       r.value = VAL_MAX;
				2, 3, 4: r.value = $signed($urandom_range(0, 8)) - 4;
				default: r.value = $urandom;
			endcase
			if (r.kind == oal_pkg::KIND_LOCATE && list_len > 0 &&
					$urandom_range(0, 9) < 6)
				r.value = list_mem[$urandom_range(0, list_len - 1)];

			if ($urandom_range(0, 99) < 15) begin
				r.position = oal_pkg::POS_W'($urandom_range(0, 63));
			end else if (r.kind == oal_pkg::KIND_INSERT) begin
				top = (list_len > 63) ? 63 : list_len;
				r.position = oal_pkg::POS_W'($urandom_range(0, top));
			end else if (list_len == 0) begin
				r.position = '0;
			end else begin
				r.position = oal_pkg::POS_W'($urandom_range(0, list_len - 1));
			end
			req_backlog.push_back(r);
		end

		while (req_backlog.size() > 0 || req.valid) @(negedge clk);
		while (rsp_due.size() > 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && rsp_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/oal_pkg.sv
rtl/core/oal_req_if.sv
rtl/core/oal_rsp_if.sv
rtl/core/oal_cell.sv
rtl/core/oal_pick.sv
rtl/core/ordered_array_list_top.sv
verif/tb.sv
